/* hw/rtl/closed_catmull_rom_path_eval_defines.svh */
// assertion macros for the catmull-rom path evaluator
`ifndef CLOSED_CATMULL_ROM_PATH_EVAL_DEFINES_SVH
`define CLOSED_CATMULL_ROM_PATH_EVAL_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define CCR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CCR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/ccr_pkg.sv */
// package with types and constants of the catmull-rom path evaluator
`default_nettype none
package ccr_pkg;
  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TotalW = 7;
  localparam int unsigned AccW = 40;
  localparam int unsigned FracW = 16;

  typedef enum logic [1:0] {
    StAdded = 2'd0,
    StEvaluated = 2'd1,
    StTooFew = 2'd2,
    StFull = 2'd3
  } status_e;

  typedef struct packed {
    logic [0:0] mode;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic signed [CoordW-1:0] target_x;
    logic signed [CoordW-1:0] target_y;
    logic signed [CoordW-1:0] target_z;
    logic [CoordW-1:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [TotalW-1:0] point_total;
    logic signed [CoordW-1:0] out_pos_x;
    logic signed [CoordW-1:0] out_pos_y;
    logic signed [CoordW-1:0] out_pos_z;
    logic signed [CoordW-1:0] out_target_x;
    logic signed [CoordW-1:0] out_target_y;
    logic signed [CoordW-1:0] out_target_z;
  } out_item_t;
endpackage
`default_nettype wire

/* hw/rtl/ccr_if.sv */
// valid/ready channel interface carrying one payload
`default_nettype none
interface ccr_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* hw/rtl/closed_catmull_rom_path_eval.sv */
// closed uniform catmull-rom path evaluator, top level
// channel | dir | payload      | transaction
// in_ch   | in  | in_item_t    | append a point or query the path
// out_ch  | out | out_item_t   | one result per input transaction
// an append writes x, y and z one by one in SWr, then loads the result in SOut
// a query runs 17 steps of serial restoring modulo, forms the indices, then works 6 axes
// (each with 5 reads, 1 coefficient step, 3 multiply/add pairs, 1 clamp), then loads the result
// reset clears the point count and the control state; the stores need no clearing.
// the input stalls while an item is in work or a result waits to be taken.
`default_nettype none
module closed_catmull_rom_path_eval #(
  parameter int unsigned MaxPoints = ccr_pkg::MaxPointsDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ccr_if.sink in_ch,
  ccr_if.source out_ch
);
  import ccr_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxPoints);
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned Depth = MaxPoints * 3;
  localparam int unsigned AddrW = $clog2(Depth);

  typedef enum logic [3:0] {
    SIdle, SWr, SMod, SIdx, SRd, SCoef, SMul, SAdd, SFin, SOut
  } state_e;

  state_e state_q;
  logic [CntW-1:0] count_q;
  in_item_t item_q;
  out_item_t res_q;
  logic out_valid_q;

  logic [CoordW-1:0] pmem [Depth];
  logic [CoordW-1:0] tmem [Depth];
  logic [CoordW-1:0] prd_q, trd_q;
  logic [AddrW-1:0] raddr;
  logic [1:0] wcnt_q;

  // serial modulo
  logic [CntW+FracW-1:0] rem_q;
  logic [4:0] mstep_q;
  logic [IdxW-1:0] seg_q, ia_q, ic_q, id_q;

  // axis loop
  logic [2:0] axis_q;
  logic [2:0] rcnt_q;
  logic signed [CoordW-1:0] va_q, vb_q, vc_q, vd_q;
  logic signed [AccW-1:0] k2_q, k1_q, k0_q, acc_q;
  logic signed [AccW+FracW:0] prod_q;
  logic [1:0] hstep_q;
  logic signed [CoordW-1:0] resv [6];

  assign in_ch.ready = (state_q == SIdle) && !out_valid_q;
  assign out_ch.valid = out_valid_q;
  assign out_ch.payload = res_q;

  function automatic logic [IdxW-1:0] wrap_inc(logic [IdxW-1:0] v, logic [CntW-1:0] n);
    logic [CntW-1:0] s;
    s = CntW'(v) + CntW'(1);
    if (s >= n) s = '0;
    return s[IdxW-1:0];
  endfunction

  function automatic out_item_t mk_res(logic [1:0] st, logic [TotalW-1:0] tot);
    out_item_t r;
    r = '0;
    r.status = st;
    r.point_total = tot;
    return r;
  endfunction

  logic [1:0] sel;
  logic [IdxW-1:0] pidx;
  always_comb begin
    sel = rcnt_q[1:0];
    unique case (sel)
      2'd0: pidx = ia_q;
      2'd1: pidx = seg_q;
      2'd2: pidx = ic_q;
      default: pidx = id_q;
    endcase
    raddr = AddrW'(pidx * 3 + (axis_q >= 3'd3 ? axis_q - 3'd3 : axis_q));
  end

  logic [AddrW-1:0] waddr;
  logic [CoordW-1:0] wpd, wtd;
  always_comb begin
    waddr = AddrW'(count_q[IdxW-1:0] * 3 + wcnt_q);
    unique case (wcnt_q)
      2'd0: begin wpd = item_q.pos_x; wtd = item_q.target_x; end
      2'd1: begin wpd = item_q.pos_y; wtd = item_q.target_y; end
      default: begin wpd = item_q.pos_z; wtd = item_q.target_z; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SWr) begin
      pmem[waddr] <= wpd;
      tmem[waddr] <= wtd;
    end
    prd_q <= pmem[raddr];
    trd_q <= tmem[raddr];
  end

  logic [CntW+FracW-1:0] msub;
  logic signed [CoordW+2:0] rdv;
  logic signed [AccW-1:0] k3c, k2c, k1c;
  logic signed [AccW+FracW:0] rsum;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] fin;
  always_comb begin
    msub = ({count_q, {FracW{1'b0}}}) >> mstep_q;
    rdv = (axis_q >= 3'd3) ? (CoordW+3)'($signed(trd_q)) : (CoordW+3)'($signed(prd_q));
    k3c = -AccW'(va_q) + 3 * AccW'(vb_q) - 3 * AccW'(vc_q) + AccW'(vd_q);
    k2c = 2 * AccW'(va_q) - 5 * AccW'(vb_q) + 4 * AccW'(vc_q) - AccW'(vd_q);
    k1c = AccW'(vc_q) - AccW'(va_q);
    rsum = prod_q + (AccW+FracW+1)'(32768);
    rnd = AccW'(rsum >>> FracW);
    fin = (acc_q + AccW'(1)) >>> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      out_valid_q <= 1'b0;
      wcnt_q <= '0;
      mstep_q <= '0;
      axis_q <= '0;
      rcnt_q <= '0;
      hstep_q <= '0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        SIdle: begin
          if (in_ch.valid && in_ch.ready) begin
            item_q <= in_ch.payload;
            wcnt_q <= '0;
            if (in_ch.payload.mode == 1'b0) begin
              if (count_q >= CntW'(MaxPoints)) begin
                res_q <= mk_res(StFull, TotalW'(count_q));
                state_q <= SOut;
              end else begin
                res_q <= mk_res(StAdded, TotalW'(count_q));
                state_q <= SWr;
              end
            end else if (count_q < CntW'(3)) begin
              res_q <= mk_res(StTooFew, TotalW'(count_q));
              state_q <= SOut;
            end else begin
              res_q <= mk_res(StAdded, TotalW'(count_q));
              rem_q <= (CntW+FracW)'(in_ch.payload.query_time[CoordW-1:FracW]);
              mstep_q <= '0;
              state_q <= SMod;
            end
          end
        end
        SWr: begin
          wcnt_q <= wcnt_q + 2'd1;
          if (wcnt_q == 2'd2) begin
            count_q <= count_q + CntW'(1);
            res_q <= mk_res(StAdded, TotalW'(count_q + CntW'(1)));
            state_q <= SOut;
          end
        end
        SMod: begin
          if (rem_q >= msub) rem_q <= rem_q - msub;
          mstep_q <= mstep_q + 5'd1;
          if (mstep_q == 5'(FracW)) state_q <= SIdx;
        end
        SIdx: begin
          seg_q <= rem_q[IdxW-1:0];
          ic_q <= wrap_inc(rem_q[IdxW-1:0], count_q);
          id_q <= wrap_inc(wrap_inc(rem_q[IdxW-1:0], count_q), count_q);
          ia_q <= (rem_q[IdxW-1:0] == '0) ? IdxW'(count_q - CntW'(1))
                                           : rem_q[IdxW-1:0] - IdxW'(1);
          axis_q <= '0;
          rcnt_q <= '0;
          state_q <= SRd;
        end
        SRd: begin
          rcnt_q <= rcnt_q + 3'd1;
          if (rcnt_q != 3'd0) begin
            va_q <= vb_q; vb_q <= vc_q; vc_q <= vd_q; vd_q <= rdv[CoordW-1:0];
          end
          if (rcnt_q == 3'd4) state_q <= SCoef;
        end
        SCoef: begin
          acc_q <= k3c;
          k2_q <= k2c;
          k1_q <= k1c;
          k0_q <= 2 * AccW'(vb_q);
          hstep_q <= '0;
          state_q <= SMul;
        end
        SMul: begin
          prod_q <= (AccW+FracW+1)'(acc_q) *
                    $signed({1'b0, item_q.query_time[FracW-1:0]});
          state_q <= SAdd;
        end
        SAdd: begin
          hstep_q <= hstep_q + 2'd1;
          unique case (hstep_q)
            2'd0: acc_q <= rnd + k2_q;
            2'd1: acc_q <= rnd + k1_q;
            default: acc_q <= rnd + k0_q;
          endcase
          state_q <= (hstep_q == 2'd2) ? SFin : SMul;
        end
        SFin: begin
          if (fin > AccW'(32'sh7fffffff)) resv[axis_q] <= 32'sh7fffffff;
          else if (fin < -AccW'(64'sh80000000)) resv[axis_q] <= 32'sh80000000;
          else resv[axis_q] <= fin[CoordW-1:0];
          rcnt_q <= '0;
          axis_q <= axis_q + 3'd1;
          state_q <= (axis_q == 3'd5) ? SOut : SRd;
          if (axis_q == 3'd5) begin
            res_q.status <= StEvaluated;
          end
        end
        SOut: begin
          if (item_q.mode == 1'b1 && res_q.status == StEvaluated) begin
            res_q <= '{status: res_q.status, point_total: res_q.point_total,
                       out_pos_x: resv[0], out_pos_y: resv[1], out_pos_z: resv[2],
                       out_target_x: resv[3], out_target_y: resv[4],
                       out_target_z: resv[5]};
          end
          out_valid_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/ccr_checker.sv */
// port-level checker for the catmull-rom path evaluator, with its bind
`default_nettype none
`include "closed_catmull_rom_path_eval_defines.svh"
module ccr_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] status,
  input wire logic [6:0] total
);
  import ccr_pkg::*;
  `CCR_ASSERT_NXT(a_no_ready_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready, "ready after accept")
  `CCR_ASSERT_IMP(a_no_ready_while_out, clk_i, rst_ni, out_valid, !in_ready, "ready with pending result")
  `CCR_ASSERT_NXT(a_out_holds, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(status), "result dropped")
  `CCR_ASSERT_IMP(a_full_total, clk_i, rst_ni, out_valid && status == StFull, total != 7'd0, "full with no points")
endmodule

bind closed_catmull_rom_path_eval ccr_checker u_ccr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.payload.status), .total(out_ch.payload.point_total)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
// testbench for the closed catmull-rom path evaluator
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ccr_pkg::*;

  localparam int unsigned MaxPts = MaxPointsDef;
  localparam longint CycleLimit = 2000000;

  logic clk_i;
  logic rst_ni;
  int unsigned err_cnt;
  longint cycles;

  ccr_if #(.payload_t(in_item_t)) in_ch ();
  ccr_if #(.payload_t(out_item_t)) out_ch ();

  closed_catmull_rom_path_eval dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_v);
    $display("mismatch %s: got %h expected %h", what, got, exp_v);
    err_cnt++;
  endtask

  class path_scoreboard;
    logic signed [31:0] pos_mem[MaxPts*3];
    logic signed [31:0] tgt_mem[MaxPts*3];
    int unsigned n_pts;
    out_item_t pending[$];

    function longint fshift(longint x, int k);
      return x >>> k;
    endfunction

    function logic [31:0] spline_axis(longint a, longint b, longint c, longint d,
                                      longint u);
      longint k3, k2, k1, k0, acc, r;
      k3 = -a + 3 * b - 3 * c + d;
      k2 = 2 * a - 5 * b + 4 * c - d;
      k1 = c - a;
      k0 = 2 * b;
      acc = k3;
      acc = fshift(acc * u + 32768, 16) + k2;
      acc = fshift(acc * u + 32768, 16) + k1;
      acc = fshift(acc * u + 32768, 16) + k0;
      r = fshift(acc + 1, 1);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
    endfunction

    function void note_input(in_item_t it);
      out_item_t o;
      int unsigned i, ia, ic, id, u;
      o = '0;
      if (it.mode == 1'b0) begin
        if (n_pts >= MaxPts) begin
          o.status = StFull;
        end else begin
          pos_mem[n_pts*3] = it.pos_x;
          pos_mem[n_pts*3+1] = it.pos_y;
          pos_mem[n_pts*3+2] = it.pos_z;
          tgt_mem[n_pts*3] = it.target_x;
          tgt_mem[n_pts*3+1] = it.target_y;
          tgt_mem[n_pts*3+2] = it.target_z;
          n_pts++;
          o.status = StAdded;
        end
      end else if (n_pts < 3) begin
        o.status = StTooFew;
      end else begin
        i = it.query_time[31:16] % n_pts;
        ia = (i + n_pts - 1) % n_pts;
        ic = (i + 1) % n_pts;
        id = (i + 2) % n_pts;
        u = it.query_time[15:0];
        o.out_pos_x = spline_axis(pos_mem[ia*3], pos_mem[i*3], pos_mem[ic*3],
                                  pos_mem[id*3], u);
        o.out_pos_y = spline_axis(pos_mem[ia*3+1], pos_mem[i*3+1], pos_mem[ic*3+1],
                                  pos_mem[id*3+1], u);
        o.out_pos_z = spline_axis(pos_mem[ia*3+2], pos_mem[i*3+2], pos_mem[ic*3+2],
                                  pos_mem[id*3+2], u);
        o.out_target_x = spline_axis(tgt_mem[ia*3], tgt_mem[i*3], tgt_mem[ic*3],
                                     tgt_mem[id*3], u);
        o.out_target_y = spline_axis(tgt_mem[ia*3+1], tgt_mem[i*3+1], tgt_mem[ic*3+1],
                                     tgt_mem[id*3+1], u);
        o.out_target_z = spline_axis(tgt_mem[ia*3+2], tgt_mem[i*3+2], tgt_mem[ic*3+2],
                                     tgt_mem[id*3+2], u);
        o.status = StEvaluated;
      end
      o.point_total = n_pts[6:0];
      pending.push_back(o);
    endfunction

    task check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result", got.status, 0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) report_mismatch("status", got.status, e.status);
      if (got.point_total !== e.point_total)
        report_mismatch("point_total", got.point_total, e.point_total);
      if (got.out_pos_x !== e.out_pos_x) report_mismatch("pos_x", got.out_pos_x, e.out_pos_x);
      if (got.out_pos_y !== e.out_pos_y) report_mismatch("pos_y", got.out_pos_y, e.out_pos_y);
      if (got.out_pos_z !== e.out_pos_z) report_mismatch("pos_z", got.out_pos_z, e.out_pos_z);
      if (got.out_target_x !== e.out_target_x)
        report_mismatch("target_x", got.out_target_x, e.out_target_x);
      if (got.out_target_y !== e.out_target_y)
        report_mismatch("target_y", got.out_target_y, e.out_target_y);
      if (got.out_target_z !== e.out_target_z)
        report_mismatch("target_z", got.out_target_z, e.out_target_z);
    endtask
  endclass

  path_scoreboard sb;
  bit idle_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_input(in_ch.payload);
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
  end

  initial begin
    cycles = 0;
    wait (cycles >= CycleLimit);
    $display("closed_catmull_rom_path_eval verification failed");
    $finish;
  end

  // result side stalls
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!idle_off && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input in_item_t it);
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_ch.payload <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_point(input logic [31:0] c);
    in_item_t it;
    it = '0;
    it.mode = 1'b0;
    it.pos_x = c; it.pos_y = ~c; it.pos_z = rand_coord();
    it.target_x = rand_coord(); it.target_y = c; it.target_z = rand_coord();
    it.query_time = $urandom;
    send_item(it);
  endtask

  task automatic send_query(input logic [31:0] t);
    in_item_t it;
    it = '0;
    it.mode = 1'b1;
    it.query_time = t;
    it.pos_x = $urandom;
    send_item(it);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    sb = new();
    err_cnt = 0;
    idle_off = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: too few points, extremes, wraps
    send_query(32'h0000_0000);
    send_point(32'h8000_0000);
    send_query(32'hffff_ffff);
    send_point(32'h7fff_ffff);
    send_point(32'h0000_0000);
    send_query(32'h0000_0000);
    send_query(32'hffff_ffff);
    send_query(32'h0002_8000);
    send_query(32'h0001_0001);
    send_point(32'h8000_0000);
    send_query(32'h0003_ffff);
    drain_results();
    // fill until full with a query at every point count, then overflow
    while (sb.n_pts < MaxPts) begin
      send_point(rand_coord());
      send_query($urandom);
    end
    send_point(32'h1234_5678);
    send_query(32'hffff_8000);
    drain_results();
    // random part in one loop; reset is not repeated, so the store stays full
    for (int k = 0; k < 1200; k++) begin
      if (k > 1000) idle_off = 1;
      if ($urandom_range(0, 9) == 0) send_point(rand_coord());
      else send_query($urandom_range(0, 3) == 0 ? $urandom_range(0, 32'h0040_ffff)
                                                : $urandom);
      if (k == 500) drain_results();
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("closed_catmull_rom_path_eval verification clean");
    end else begin
      $display("closed_catmull_rom_path_eval verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
